// ===== hdl/hlsc_pkg.sv =====
package hlsc_pkg;

  localparam int MAX_LINE = 64;
  localparam int MAX_WORD = 12;
  localparam int IDX_W = $clog2(MAX_LINE);
  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int WL_W = $clog2(MAX_WORD + 2);
  localparam int WI_W = $clog2(MAX_WORD);
  localparam int TAG_COUNT = 77;
  localparam int ATTR_COUNT = 17;
  localparam int ROM_W = 16;

  localparam logic [2:0] CL_DEFAULT = 3'd0;
  localparam logic [2:0] CL_COMMENT = 3'd1;
  localparam logic [2:0] CL_TAG = 3'd2;
  localparam logic [2:0] CL_KEYWORD = 3'd3;
  localparam logic [2:0] CL_ATTRIB = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       starts_in_comment;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [2:0] char_class;
    logic       last_of_line;
    logic       ends_in_comment;
  } out_word_t;

  typedef logic [ROM_W*8-1:0] rom_word_t;

  function automatic rom_word_t pad(input string s);
    rom_word_t r;
    r = '0;
    for (int i = 0; i < s.len() && i < ROM_W; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic rom_word_t tag_rom(input logic [6:0] e);
    rom_word_t r;
    unique case (e)
      7'd0: r = pad("a");        7'd1: r = pad("abbr");     7'd2: r = pad("acronym");
      7'd3: r = pad("address");  7'd4: r = pad("area");     7'd5: r = pad("b");
      7'd6: r = pad("base");     7'd7: r = pad("bdo");      7'd8: r = pad("big");
      7'd9: r = pad("blockquote"); 7'd10: r = pad("body");  7'd11: r = pad("br");
      7'd12: r = pad("button");  7'd13: r = pad("caption"); 7'd14: r = pad("cite");
      7'd15: r = pad("code");    7'd16: r = pad("col");     7'd17: r = pad("colgroup");
      7'd18: r = pad("dd");      7'd19: r = pad("del");     7'd20: r = pad("dfn");
      7'd21: r = pad("div");     7'd22: r = pad("dl");      7'd23: r = pad("dt");
      7'd24: r = pad("em");      7'd25: r = pad("fieldset"); 7'd26: r = pad("form");
      7'd27: r = pad("h1");      7'd28: r = pad("h2");      7'd29: r = pad("h3");
      7'd30: r = pad("h4");      7'd31: r = pad("h5");      7'd32: r = pad("h6");
      7'd33: r = pad("head");    7'd34: r = pad("hr");      7'd35: r = pad("html");
      7'd36: r = pad("i");       7'd37: r = pad("img");     7'd38: r = pad("input");
      7'd39: r = pad("ins");     7'd40: r = pad("kbd");     7'd41: r = pad("label");
      7'd42: r = pad("legend");  7'd43: r = pad("li");      7'd44: r = pad("link");
      7'd45: r = pad("map");     7'd46: r = pad("meta");    7'd47: r = pad("noscript");
      7'd48: r = pad("object");  7'd49: r = pad("ol");      7'd50: r = pad("optgroup");
      7'd51: r = pad("option");  7'd52: r = pad("p");       7'd53: r = pad("param");
      7'd54: r = pad("pre");     7'd55: r = pad("q");       7'd56: r = pad("samp");
      7'd57: r = pad("script");  7'd58: r = pad("select");  7'd59: r = pad("small");
      7'd60: r = pad("span");    7'd61: r = pad("strong");  7'd62: r = pad("style");
      7'd63: r = pad("sub");     7'd64: r = pad("sup");     7'd65: r = pad("table");
      7'd66: r = pad("tbody");   7'd67: r = pad("td");      7'd68: r = pad("textarea");
      7'd69: r = pad("tfoot");   7'd70: r = pad("th");      7'd71: r = pad("thead");
      7'd72: r = pad("title");   7'd73: r = pad("tr");      7'd74: r = pad("tt");
      7'd75: r = pad("ul");      7'd76: r = pad("var");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_word_t attr_rom(input logic [6:0] e);
    rom_word_t r;
    unique case (e)
      7'd0: r = pad("align=");        7'd1: r = pad("background=");
      7'd2: r = pad("bgcolor=");      7'd3: r = pad("border=");
      7'd4: r = pad("bordercolor=");  7'd5: r = pad("cellpadding=");
      7'd6: r = pad("cellspacing=");  7'd7: r = pad("face=");
      7'd8: r = pad("height=");       7'd9: r = pad("href=");
      7'd10: r = pad("link=");        7'd11: r = pad("size=");
      7'd12: r = pad("src=");         7'd13: r = pad("text=");
      7'd14: r = pad("type=");        7'd15: r = pad("vlink=");
      7'd16: r = pad("width=");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h3d || c == 8'h2f;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== hdl/html_line_syntax_classifier.sv =====
// sequence: bytes load while busy is low; after the end-of-line byte a context pass
// classes every byte, a word pass scans for tag names and attributes, each word is
// compared against the ROM entries and matched bytes are marked, then one result per byte
// throughput: sequential, the next line loads once busy drops after its last result
// reset: synchronous, clears the sequencer and length; the receiver cannot stall
module html_line_syntax_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hlsc_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                result_valid,
  output hlsc_pkg::out_word_t result
);
  import hlsc_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_CX, S_SCAN, S_WEND, S_ROM, S_MARK, S_OUT
  } state_t;

  state_t state;
  logic [7:0] line_store [MAX_LINE];
  logic [2:0] class_store [MAX_LINE];
  logic [LEN_W-1:0] line_length, a, ra, st, en, mi;
  logic [WL_W-1:0] wl;
  logic [2:0] fill;
  logic [6:0] rom_e;
  logic [7:0] rd_c, w0, w1, w2, w3, nxt;
  logic [2:0] rd_k;
  logic [7:0] wbuf [MAX_WORD];
  logic initial_comment, started, ob_c, ob_t, ends, is_kw, rd_wait;

  // window of line bytes used by the context pass
  assign nxt = (ra < line_length) ? rd_c : 8'h0;

  logic nb_c, nb_t, close3;
  logic [2:0] kx;
  always_comb begin
    nb_c = ob_c; nb_t = ob_t;
    if (w0 == 8'h3c) begin
      if (a + 3 < line_length && w1 == 8'h21 && w2 == 8'h2d && w3 == 8'h2d) nb_c = 1'b1;
      else nb_t = 1'b1;
    end else if (w0 == 8'h3e && ob_t && !ob_c) nb_t = 1'b0;
    kx = nb_c ? CL_COMMENT : (nb_t ? CL_TAG : CL_DEFAULT);
    if (ob_t && !nb_t) kx = CL_TAG;
    close3 = w0 == 8'h2d && ob_c && a + 2 < line_length && w1 == 8'h2d && w2 == 8'h3e;
  end

  rom_word_t rw;
  logic rom_match;
  always_comb begin
    rw = is_kw ? tag_rom(rom_e) : attr_rom(rom_e);
    rom_match = rw[wl*8 +: 8] == 8'h0;
    for (int i = 0; i < MAX_WORD; i++)
      if (i < wl && rw[i*8 +: 8] != wbuf[i]) rom_match = 1'b0;
  end

  assign busy = state != S_LOAD;

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    rd_c <= line_store[ra[IDX_W-1:0]];
    rd_k <= class_store[ra[IDX_W-1:0]];
    if (rst) begin
      state <= S_LOAD; line_length <= '0; initial_comment <= 1'b0; started <= 1'b0;
      rd_wait <= 1'b0;
    end else if (rd_wait) begin
      rd_wait <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (start) begin
          if (!started) initial_comment <= in_word.starts_in_comment;
          started <= !in_word.end_of_line;
          if (!started || line_length < MAX_LINE) begin
            line_store[started ? line_length[IDX_W-1:0] : '0] <= in_word.char_code;
          end
          if (!started) line_length <= LEN_W'(1);
          else if (line_length < MAX_LINE) line_length <= line_length + 1'b1;
          if (in_word.end_of_line) begin
            a <= '0; ra <= '0; fill <= 3'd4; rd_wait <= 1'b1;
            ob_c <= started ? initial_comment : in_word.starts_in_comment;
            ob_t <= 1'b0;
            state <= S_CX;
          end
        end
        S_CX: begin
          if (fill == 3'd0 && a >= line_length) begin
            ends <= ob_c; a <= '0; ra <= '0; rd_wait <= 1'b1; state <= S_SCAN;
          end else begin
            w0 <= w1; w1 <= w2; w2 <= w3; w3 <= nxt;
            ra <= ra + 1'b1; rd_wait <= 1'b1;
            if (fill != 3'd0) fill <= fill - 1'b1;
            else begin
              class_store[a[IDX_W-1:0]] <= close3 ? CL_COMMENT : kx;
              ob_t <= nb_t;
              ob_c <= close3 ? 1'b0 : nb_c;
              a <= a + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (a >= line_length) begin
            a <= '0; ra <= '0; rd_wait <= 1'b1; state <= S_OUT;
          end else begin
            if (rd_c == 8'h3c || (rd_k == CL_TAG && is_letter(rd_c))) begin
              st <= a; is_kw <= rd_c == 8'h3c;
              wbuf[0] <= lower(rd_c);
              wl <= (rd_c == 8'h3c) ? '0 : WL_W'(1);
              state <= S_WEND;
            end
            a <= a + 1'b1; ra <= a + 1'b1; rd_wait <= 1'b1;
          end
        end
        S_WEND: begin
          if (a < line_length && rd_k == CL_TAG && is_word_byte(rd_c)) begin
            // slash right after the opening bracket is not part of the name
            if (!(is_kw && a == st + 1'b1 && rd_c == 8'h2f)) begin
              if (wl < MAX_WORD) wbuf[wl[WI_W-1:0]] <= lower(rd_c);
              if (wl <= MAX_WORD) wl <= wl + 1'b1;
            end
            if (rd_c == 8'h3d) begin
              en <= a + 1'b1; rom_e <= '0; state <= S_ROM;
              if (is_kw) st <= st + 1'b1;
            end else begin
              a <= a + 1'b1; ra <= a + 1'b1; rd_wait <= 1'b1;
            end
          end else begin
            en <= a; rom_e <= '0; state <= S_ROM;
            if (is_kw) st <= st + 1'b1;
          end
        end
        S_ROM: begin
          if (wl == '0 || wl > MAX_WORD) begin
            a <= en + 1'b1; ra <= en + 1'b1; rd_wait <= 1'b1; state <= S_SCAN;
          end else if (rom_match) begin
            mi <= st; state <= S_MARK;
          end else if (rom_e == 7'((is_kw ? TAG_COUNT : ATTR_COUNT) - 1)) begin
            a <= en + 1'b1; ra <= en + 1'b1; rd_wait <= 1'b1; state <= S_SCAN;
          end else rom_e <= rom_e + 1'b1;
        end
        S_MARK: begin
          if (mi < en && mi < MAX_LINE) begin
            class_store[mi[IDX_W-1:0]] <= is_kw ? CL_KEYWORD : CL_ATTRIB;
            mi <= mi + 1'b1;
          end else begin
            a <= en + 1'b1; ra <= en + 1'b1; rd_wait <= 1'b1; state <= S_SCAN;
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          result.char_class <= rd_k;
          result.last_of_line <= a + 1'b1 == line_length;
          result.ends_in_comment <= ends;
          if (a + 1'b1 == line_length) begin
            line_length <= '0; state <= S_LOAD;
          end else begin
            a <= a + 1'b1; ra <= a + 1'b1; rd_wait <= 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
